>>> sv/minimum_image_voronoi_wrap_macros.svh
// ---------------------------------------------------------------------------
// Minimum image wrap assertion macros
// Concurrent assertion helpers, empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef MINIMUM_IMAGE_VORONOI_WRAP_MACROS_SVH
`define MINIMUM_IMAGE_VORONOI_WRAP_MACROS_SVH
`ifndef SYNTHESIS
`define MIV_AST_IMP(lbl, ck, rst, a, c) \
	lbl: assert property (@(posedge ck) disable iff (rst) (a) |-> (c)) \
	else $error("minimum image wrap assertion failed");
`define MIV_AST_NXT(lbl, ck, rst, a, c) \
	lbl: assert property (@(posedge ck) disable iff (rst) (a) |=> (c)) \
	else $error("minimum image wrap assertion failed");
`else
`define MIV_AST_IMP(lbl, ck, rst, a, c)
`define MIV_AST_NXT(lbl, ck, rst, a, c)
`endif
`endif

>>> sv/miv_pkg.sv
// ---------------------------------------------------------------------------
// Minimum image wrap package
// Register indexes and fixed datapath widths.
// ---------------------------------------------------------------------------
package miv_pkg;
	localparam int ENT_W = 18;
	localparam int VEC_W = 32;
	localparam int CW    = 26;
	localparam int NW    = 60;
	localparam int NCAND = 27;

	typedef enum logic [2:0] {
		REG_CELL_X  = 3'd0,
		REG_CELL_Y  = 3'd1,
		REG_CELL_Z  = 3'd2,
		REG_INV_X   = 3'd3,
		REG_INV_Y   = 3'd4,
		REG_INV_Z   = 3'd5,
		REG_CTOL    = 3'd6,
		REG_NTOL    = 3'd7
	} reg_idx_t;
endpackage

>>> sv/minimum_image_voronoi_wrap.sv
// ---------------------------------------------------------------------------
// Minimum image wrap
// Shortest periodic image of a Cartesian vector over the 27 neighbor shifts.
// ---------------------------------------------------------------------------
// channel   role     handshake                 payload
// s_axis    input    tvalid/tready             vec_x, vec_y, vec_z
// m_axis    output   tvalid/tready             image_x, image_y, image_z
// apb       config   psel/penable/pwrite       cell, inverse, tolerances
// One request enters per cycle while the output is not stalled. The pipeline
// has 12 register stages: products, sums, norm terms, and four compare stages
// of the ordered shift search, seven candidates each but six in the last.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// arst_n clears all valid bits and loads the identity cell.
// ---------------------------------------------------------------------------
`include "minimum_image_voronoi_wrap_macros.svh"

module minimum_image_voronoi_wrap
	import miv_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vec_x [31:0], vec_y [63:32], vec_z [95:64]
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// image_x [31:0], image_y [63:32], image_z [95:64]
	output logic [95:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	localparam int FXW = 49;
	localparam int GA [6] = '{0, 1, 2, 0, 0, 1};
	localparam int GB [6] = '{0, 1, 2, 1, 2, 2};

	logic [53:0] cell_q [3];
	logic [53:0] inv_q [3];
	logic [15:0] ctol_q;
	logic [31:0] ntol_q;

	function automatic logic signed [ENT_W-1:0] ent(input logic [53:0] row, input int c);
		return $signed(row[18*c +: 18]);
	endfunction

	function automatic logic signed [NW-1:0] smul(input int s,
			input logic signed [NW-1:0] v);
		case (s)
			1:       return v;
			-1:      return -v;
			2:       return v <<< 1;
			-2:      return -(v <<< 1);
			default: return '0;
		endcase
	endfunction

	// configuration
	reg_idx_t widx;
	assign widx = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q[0] <= 54'd4096;
			cell_q[1] <= 54'd4096 << 18;
			cell_q[2] <= 54'd4096 << 36;
			inv_q[0] <= 54'd65536;
			inv_q[1] <= 54'd65536 << 18;
			inv_q[2] <= 54'd65536 << 36;
			ctol_q <= 16'd1;
			ntol_q <= 32'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_CELL_X: cell_q[0] <= pwdata[53:0];
				REG_CELL_Y: cell_q[1] <= pwdata[53:0];
				REG_CELL_Z: cell_q[2] <= pwdata[53:0];
				REG_INV_X:  inv_q[0] <= pwdata[53:0];
				REG_INV_Y:  inv_q[1] <= pwdata[53:0];
				REG_INV_Z:  inv_q[2] <= pwdata[53:0];
				REG_CTOL:   ctol_q <= pwdata[15:0];
				REG_NTOL:   ntol_q <= pwdata[31:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_CELL_X: prdata = {10'd0, cell_q[0]};
			REG_CELL_Y: prdata = {10'd0, cell_q[1]};
			REG_CELL_Z: prdata = {10'd0, cell_q[2]};
			REG_INV_X:  prdata = {10'd0, inv_q[0]};
			REG_INV_Y:  prdata = {10'd0, inv_q[1]};
			REG_INV_Z:  prdata = {10'd0, inv_q[2]};
			REG_CTOL:   prdata = {48'd0, ctol_q};
			REG_NTOL:   prdata = {32'd0, ntol_q};
			default:    prdata = '0;
		endcase
	end

	// pipeline control
	logic en;
	logic out_v_q;
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic sel_v_s [0:4];

	logic signed [49:0] pinv_s1 [3][3];
	logic signed [17:0] orig_s2 [3];
	logic signed [35:0] pcel_s3 [3][3];
	logic signed [CW-1:0] cart_s4 [3];
	logic signed [51:0] sq_s5 [3];
	logic signed [43:0] pp_s5 [3][3];
	logic signed [35:0] gp_s5 [6][3];
	logic signed [CW-1:0] cart_s5 [3];
	logic signed [NW-1:0] n0_s6;
	logic signed [45:0] p_s6 [3];
	logic signed [37:0] g_s6 [6];
	logic signed [CW-1:0] cart_s6 [3];
	logic [NW-1:0] sel_d_s [0:4][NCAND];
	logic [NW-1:0] sel_m_s [0:4];
	logic [5:0] sel_b_s [0:4];
	logic signed [CW-1:0] sel_c_s [0:4][3];
	logic [31:0] image_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int s = 0; s < 5; s++) sel_v_s[s] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			sel_v_s[0] <= vld_s6;
			for (int s = 0; s < 4; s++) sel_v_s[s+1] <= sel_v_s[s];
			out_v_q <= sel_v_s[4];
		end
	end

	// combinational stage logic
	logic signed [49:0] pinv_d [3][3];
	logic signed [17:0] orig_d [3];
	logic signed [35:0] pcel_d [3][3];
	logic signed [CW-1:0] cart_d [3];
	logic [NW-1:0] d_d [NCAND];
	logic [NW-1:0] m_d [0:3];
	logic [5:0] b_d [0:3];
	logic [31:0] img_d [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				pinv_d[r][c] = ent(inv_q[r], c) * $signed(s_axis_tdata[32*c +: 32]);
	end

	always_comb begin
		logic signed [51:0] acc;
		logic signed [FXW-1:0] fx;
		logic ovf;
		logic [15:0] low;
		logic [15:0] wrap;
		logic signed [17:0] f;
		logic signed [18:0] fw;
		logic signed [18:0] tw;
		for (int r = 0; r < 3; r++) begin
			acc = pinv_s1[r][0] + pinv_s1[r][1] + pinv_s1[r][2];
			fx = FXW'($signed(acc[51:16]));
			ovf = !((&fx[FXW-1:COORD_BITS-1]) || !(|fx[FXW-1:COORD_BITS-1]));
			low = ovf ? (fx[FXW-1] ? 16'h0000 : 16'hFFFF) : fx[15:0];
			wrap = low + ctol_q;
			f = $signed({2'b00, wrap}) - $signed({2'b00, ctol_q});
			fw = f;
			tw = $signed({3'b000, ctol_q});
			if ((19'sd65536 - fw < tw) || (fw + 19'sd65536 < tw))
				orig_d[r] = '0;
			else
				orig_d[r] = f;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				pcel_d[r][c] = ent(cell_q[r], c) * orig_s2[c];
	end

	always_comb begin
		logic signed [37:0] acc;
		for (int r = 0; r < 3; r++) begin
			acc = pcel_s3[r][0] + pcel_s3[r][1] + pcel_s3[r][2];
			cart_d[r] = acc[37:12];
		end
	end

	always_comb begin
		logic signed [NW-1:0] lin;
		logic signed [NW-1:0] quad;
		logic signed [NW-1:0] dv;
		for (int i = -1; i < 2; i++)
			for (int j = -1; j < 2; j++)
				for (int k = -1; k < 2; k++) begin
					lin = smul(i, NW'(p_s6[0])) + smul(j, NW'(p_s6[1]))
						+ smul(k, NW'(p_s6[2]));
					quad = smul(i * i, NW'(g_s6[0])) + smul(j * j, NW'(g_s6[1]))
						+ smul(k * k, NW'(g_s6[2])) + smul(2 * i * j, NW'(g_s6[3]))
						+ smul(2 * i * k, NW'(g_s6[4])) + smul(2 * j * k, NW'(g_s6[5]));
					dv = n0_s6 + (lin <<< 5) + (quad <<< 8);
					d_d[9 * (i + 1) + 3 * (j + 1) + k + 1] = dv;
				end
	end

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			m_d[s] = sel_m_s[s];
			b_d[s] = sel_b_s[s];
			for (int i = -1; i < 2; i++)
				for (int j = -1; j < 2; j++)
					for (int k = -1; k < 2; k++) begin
						if ((9 * (i + 1) + 3 * (j + 1) + k + 1) >= 7 * s
								&& (9 * (i + 1) + 3 * (j + 1) + k + 1) < 7 * s + 7) begin
							if (m_d[s] > sel_d_s[s][9 * (i + 1) + 3 * (j + 1) + k + 1]
									+ {{(NW-32){1'b0}}, ntol_q}) begin
								m_d[s] = sel_d_s[s][9 * (i + 1) + 3 * (j + 1) + k + 1];
								b_d[s] = {2'(i), 2'(j), 2'(k)};
							end
						end
					end
		end
	end

	always_comb begin
		logic signed [NW-1:0] sum;
		for (int r = 0; r < 3; r++) begin
			sum = '0;
			for (int c = 0; c < 3; c++)
				sum = sum + smul(int'($signed(sel_b_s[4][4 - 2 * c +: 2])),
					NW'(ent(cell_q[r], c)));
			sum = NW'(sel_c_s[4][r]) + (sum <<< 4);
			img_d[r] = sum[31:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			pinv_s1 <= pinv_d;
			orig_s2 <= orig_d;
			pcel_s3 <= pcel_d;
			cart_s4 <= cart_d;
			for (int r = 0; r < 3; r++) begin
				sq_s5[r] <= cart_s4[r] * cart_s4[r];
				for (int c = 0; c < 3; c++)
					pp_s5[r][c] <= cart_s4[r] * ent(cell_q[r], c);
				for (int g = 0; g < 6; g++)
					gp_s5[g][r] <= ent(cell_q[r], GA[g]) * ent(cell_q[r], GB[g]);
			end
			cart_s5 <= cart_s4;
			n0_s6 <= NW'(sq_s5[0]) + NW'(sq_s5[1]) + NW'(sq_s5[2]);
			for (int c = 0; c < 3; c++)
				p_s6[c] <= 46'(pp_s5[0][c]) + 46'(pp_s5[1][c]) + 46'(pp_s5[2][c]);
			for (int g = 0; g < 6; g++)
				g_s6[g] <= 38'(gp_s5[g][0]) + 38'(gp_s5[g][1]) + 38'(gp_s5[g][2]);
			cart_s6 <= cart_s5;
			sel_d_s[0] <= d_d;
			sel_m_s[0] <= n0_s6;
			sel_b_s[0] <= '0;
			sel_c_s[0] <= cart_s6;
			for (int s = 0; s < 4; s++) begin
				sel_d_s[s+1] <= sel_d_s[s];
				sel_m_s[s+1] <= m_d[s];
				sel_b_s[s+1] <= b_d[s];
				sel_c_s[s+1] <= sel_c_s[s];
			end
			image_q <= img_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {image_q[2], image_q[1], image_q[0]};

	`MIV_AST_NXT(a_norm_mono, clk, !arst_n, en && sel_v_s[0], sel_m_s[1] <= $past(sel_m_s[0]))
	`MIV_AST_IMP(a_orig_rng, clk, !arst_n, vld_s2, (orig_s2[0] >= -18'sd65535) && (orig_s2[1] >= -18'sd65535) && (orig_s2[2] >= -18'sd65535))
	`MIV_AST_IMP(a_out_src, clk, !arst_n, $rose(out_v_q), $past(sel_v_s[4]))
	`MIV_AST_IMP(a_stall_src, clk, !arst_n, !s_axis_tready, out_v_q && !m_axis_tready)
endmodule

>>> dv/minimum_image_voronoi_wrap_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Minimum image wrap testbench
// Streams vectors through the wrap under a range of cell and tolerance
// settings and idle patterns. Every image is checked against an in-bench
// fixed-point predictor of the 27-shift search.
// ---------------------------------------------------------------------------
module minimum_image_voronoi_wrap_test;
	import miv_pkg::*;

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} vec3_t;

	localparam int  ONE       = 65536;
	localparam int  CYC_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	logic [53:0] cell_q [3];
	logic [53:0] inv_q [3];
	longint      ctol;
	longint unsigned ntol;

	vec3_t images_due [$];
	int    mismatches = 0;
	int    gap_pct = 0;
	int    stall_pct = 0;
	int    hold_cycles = 0;
	int    cycles = 0;

	minimum_image_voronoi_wrap i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint entry(logic [53:0] row, int col);
		logic signed [17:0] e;
		e = row[18*col +: 18];
		return longint'(e);
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic void frac_to_cart(input longint f[3], output longint c[3]);
		longint acc;
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += entry(cell_q[r], k) * f[k];
			c[r] = clamp(acc >>> 12, 32);
		end
	endfunction

	function automatic longint unsigned norm_sq(input longint f[3]);
		longint c[3];
		longint unsigned n;
		frac_to_cart(f, c);
		n = 0;
		for (int r = 0; r < 3; r++)
			n += longint'(c[r] * c[r]);
		return n;
	endfunction

	function automatic vec3_t shortest_image(vec3_t v_in);
		longint v[3], orig[3], best[3], cand[3], c[3];
		longint acc, f, q;
		longint unsigned m, d;
		vec3_t res;
		v[0] = longint'($signed(v_in.x));
		v[1] = longint'($signed(v_in.y));
		v[2] = longint'($signed(v_in.z));
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += entry(inv_q[r], k) * v[k];
			f = clamp(acc >>> 16, 32);
			q = (f + ctol) >>> 16;
			f -= q * ONE;
			if ((f - ONE < ctol && ONE - f < ctol) || (f + ONE < ctol && -ONE - f < ctol))
				f = 0;
			orig[r] = f;
			best[r] = f;
		end
		m = norm_sq(orig);
		for (int i = -1; i < 2; i++)
			for (int j = -1; j < 2; j++)
				for (int k = -1; k < 2; k++) begin
					cand[0] = orig[0] + i * ONE;
					cand[1] = orig[1] + j * ONE;
					cand[2] = orig[2] + k * ONE;
					d = norm_sq(cand);
					if (m > d + ntol) begin
						m = d;
						best = cand;
					end
				end
		frac_to_cart(best, c);
		res.x = c[0][31:0];
		res.y = c[1][31:0];
		res.z = c[2][31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stall plus long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		vec3_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (images_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected image %h", got);
			end else begin
				want = images_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("image mismatch: expected x=%h y=%h z=%h got x=%h y=%h z=%h",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
	end

	task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		vec3_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		images_due.push_back(shortest_image(v));
	endtask

	task automatic drain();
		if (s_axis_tvalid) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (images_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		case (idx)
		REG_CELL_X, REG_CELL_Y, REG_CELL_Z: cell_q[int'(idx)] = val[53:0];
		REG_INV_X, REG_INV_Y, REG_INV_Z: inv_q[int'(idx) - 3] = val[53:0];
		REG_CTOL: ctol = longint'(val[15:0]);
		REG_NTOL: ntol = longint'(val[31:0]);
		default: ;
		endcase
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 6'(int'(idx) * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] row3(logic [17:0] a, logic [17:0] b, logic [17:0] c);
		return {10'd0, c, b, a};
	endfunction

	task automatic load_cell(logic [17:0] lx, logic [17:0] ly, logic [17:0] lz,
			logic [17:0] ix, logic [17:0] iy, logic [17:0] iz);
		write_reg(REG_CELL_X, row3(lx, 18'd0, 18'd0));
		write_reg(REG_CELL_Y, row3(18'd0, ly, 18'd0));
		write_reg(REG_CELL_Z, row3(18'd0, 18'd0, lz));
		write_reg(REG_INV_X, row3(ix, 18'd0, 18'd0));
		write_reg(REG_INV_Y, row3(18'd0, iy, 18'd0));
		write_reg(REG_INV_Z, row3(18'd0, 18'd0, iz));
	endtask

	function automatic logic [31:0] rnd_coord();
		if ($urandom_range(3) == 0) return $urandom;
		return 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_vec(rnd_coord(), rnd_coord(), rnd_coord());
	endtask

	task automatic test_directed();
		logic [31:0] pts [10] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h8000,
			32'hffff8000, 32'hffff, 32'h10000, 32'hffff0000, 32'h18000, 32'h1};
		for (int i = 0; i < 10; i++)
			send_vec(pts[i], pts[(i + 3) % 10], pts[(i + 7) % 10]);
		drain();
		write_reg(REG_CTOL, 64'd16);
		send_vec(32'hfffa, 32'hffff0006, 32'h0001fff8);
		send_vec(32'h10005, 32'hfffefff9, 32'h0);
		drain();
		write_reg(REG_CTOL, 64'hffff);
		write_reg(REG_NTOL, 64'h0);
		send_vec(32'h8000, 32'h7fff, 32'hffff8001);
		send_vec(32'h12345678, 32'h87654321, 32'h0000ffff);
		drain();
		write_reg(REG_CTOL, 64'h0);
		write_reg(REG_NTOL, 64'hffffffff);
		send_vec(32'h8000, 32'h18000, 32'hfffe8000);
		send_vec(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		drain();
	endtask

	task automatic test_extremes();
		// saturated fractional coordinates
		write_reg(REG_INV_X, row3(18'h1ffff, 18'h1ffff, 18'h1ffff));
		write_reg(REG_INV_Y, row3(18'h20000, 18'h20000, 18'h20000));
		write_reg(REG_CELL_X, row3(18'h1ffff, 18'h20000, 18'h1ffff));
		write_reg(REG_CELL_Z, 64'hffffffffffffffff);
		send_vec(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_vec(32'h80000000, 32'h80000000, 32'h80000000);
		send_vec(32'h7fffffff, 32'h80000000, 32'h1);
		send_random(12);
		drain();
		write_reg(REG_CELL_Y, 64'h0);
		write_reg(REG_INV_Z, 64'h0);
		send_random(10);
		drain();
	endtask

	task automatic test_random_cells(int n);
		for (int p = 0; p < 4; p++) begin
			if (p == 0) begin
				load_cell(18'd4096, 18'd4096, 18'd4096, 18'd65536, 18'd65536, 18'd65536);
			end else if (p == 1) begin
				load_cell(18'd40960, 18'd20480, 18'd8192, 18'd6554, 18'd13107, 18'd32768);
			end else begin
				for (int r = 0; r < 3; r++) begin
					write_reg(reg_idx_t'(r), {$urandom, $urandom});
					write_reg(reg_idx_t'(r + 3), {$urandom, $urandom});
				end
			end
			write_reg(REG_CTOL, 64'($urandom_range(64)));
			write_reg(REG_NTOL, 64'($urandom_range(1 << 20)));
			send_random(n);
			drain();
		end
	endtask

	task automatic test_pressure();
		load_cell(18'd12288, 18'd8192, 18'd16384, 18'd21845, 18'd32768, 18'd16384);
		gap_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_cycles = 200;
		send_random(40);
		drain();
		send_random(20);
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cell_q[0] = row3(18'd4096, 18'd0, 18'd0);
		cell_q[1] = row3(18'd0, 18'd4096, 18'd0);
		cell_q[2] = row3(18'd0, 18'd0, 18'd4096);
		inv_q[0] = row3(18'd65536, 18'd0, 18'd0);
		inv_q[1] = row3(18'd0, 18'd65536, 18'd0);
		inv_q[2] = row3(18'd0, 18'd0, 18'd65536);
		ctol = 1;
		ntol = 1;
		test_directed();
		test_extremes();
		gap_pct = 0;  stall_pct = 0;  test_random_cells(35);
		gap_pct = 75; stall_pct = 0;  test_random_cells(35);
		gap_pct = 0;  stall_pct = 75; test_random_cells(35);
		gap_pct = 22; stall_pct = 22; test_random_cells(35);
		test_pressure();
		drain();
		repeat (30) @(posedge clk);
		if (images_due.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/miv_pkg.sv
sv/minimum_image_voronoi_wrap.sv
dv/minimum_image_voronoi_wrap_test.sv
